[rtl/core/ecpsm_pkg.sv]
// Shared types and constants for the elliptic-curve scalar multiplier.
// No dependencies; imported by ecpsm_unit and ec_point_scalar_multiply.
`default_nettype none

package ecpsm_pkg;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FIELD_PRIME = 1'b0,
        REG_CURVE_A     = 1'b1
    } cfg_reg_t;

    // Reset value of the field prime (2^32 - 5), sliced to the field width
    localparam logic [63:0] PRIME_RESET = 64'd4294967291;

    // Serial unit operations
    typedef enum logic {
        UOP_MUL = 1'b0,   // addend * bits mod m
        UOP_DIV = 1'b1    // bits / divisor; quotient * addend mod m
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

`default_nettype wire

[rtl/core/ec_point_scalar_multiply.sv]
// Work: SCALAR_BITS steps of a doubling plus, for a set bit, an addition or a second doubling;
// each, unless a point is at infinity, uses one Euclid inverse of up to ~1.45*FIELD_BITS iterations
// plus three (addition) or four (doubling) multiplies. One beat in flight; s_ready only when idle.
// Multiplies and inverse division steps run in the shared bit-serial unit (ecpsm_unit), one bit per cycle.
// Reset: synchronous active-low aresetn; field_prime = 2^32-5, curve_a = 0, no output pending.
`default_nettype none

module ec_point_scalar_multiply #(
    parameter int FIELD_BITS  = 32,
    parameter int SCALAR_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ecpsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [FIELD_BITS-1:0]               cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [SCALAR_BITS-1:0]              s_scalar,
    input  wire logic [FIELD_BITS-1:0]               s_base_x,
    input  wire logic [FIELD_BITS-1:0]               s_base_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [FIELD_BITS-1:0]                    m_result_x,
    output logic [FIELD_BITS-1:0]                    m_result_y,
    output logic                                     m_at_infinity,
    output logic                                     m_fault
);
    import ecpsm_pkg::*;

    localparam int IDX_W = $clog2(SCALAR_BITS);

    typedef logic [FIELD_BITS-1:0] fe_t;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_RA, S_RX, S_RY,
        S_DBL, S_D1, S_D2, S_D3, S_D5, S_D6, S_D7, S_D8, S_D9,
        S_POST, S_ADD, S_A1, S_A2, S_A3, S_A4, S_A5,
        S_INV_LOOP, S_INV_UPD, S_STEP, S_FIN
    } state_t;

    function automatic fe_t add_m(input fe_t u, input fe_t v, input fe_t m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic fe_t sub_m(input fe_t u, input fe_t v, input fe_t m);
        return (u >= v) ? (u - v) : (u + (m - v));
    endfunction

    state_t                 state_reg, ret_reg, inv_ret_reg;
    fe_t                    prime_reg, curve_a_reg;
    fe_t                    m_reg, a_reg;
    logic [SCALAR_BITS-1:0] k_reg;
    fe_t                    gx_reg, gy_reg, rx_reg, ry_reg;
    fe_t                    tmp_reg, num_reg, kk_reg;
    fe_t                    r0_reg, r1_reg, t0_reg, t1_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   second_reg;
    logic                   fault_reg;
    logic                   m_valid_reg;
    fe_t                    out_x_reg, out_y_reg;
    logic                   out_inf_reg, out_fault_reg;

    unit_ctl_t u_ctl;
    unit_sts_t u_sts;
    fe_t       u_bits, u_addend, u_div, u_acc, u_rem;

    logic prime_small;
    logic r_inf, g_inf;
    logic fin_fire;

    assign prime_small = (prime_reg < FIELD_BITS'(3));
    assign r_inf       = (rx_reg == '0) && (ry_reg == '0);
    assign g_inf       = (gx_reg == '0) && (gy_reg == '0);
    assign s_ready     = (state_reg == S_IDLE);
    assign fin_fire    = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // Operand select for the shared unit
    always_comb begin
        u_ctl.start = 1'b0;
        u_ctl.op    = UOP_MUL;
        u_bits      = '0;
        u_addend    = '0;
        u_div       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && !prime_small) begin
                    u_ctl.start = 1'b1;
                    u_addend    = FIELD_BITS'(1);
                    u_bits      = curve_a_reg;
                end
            end
            S_RA: begin
                u_ctl.start = 1'b1;
                u_addend    = FIELD_BITS'(1);
                u_bits      = gx_reg;
            end
            S_RX: begin
                u_ctl.start = 1'b1;
                u_addend    = FIELD_BITS'(1);
                u_bits      = gy_reg;
            end
            S_DBL: begin
                if (!r_inf && ry_reg != '0) begin
                    u_ctl.start = 1'b1;
                    u_addend    = rx_reg;
                    u_bits      = rx_reg;
                end
            end
            S_INV_LOOP: begin
                if (r1_reg != '0) begin
                    u_ctl.start = 1'b1;
                    u_ctl.op    = UOP_DIV;
                    u_bits      = r0_reg;
                    u_div       = r1_reg;
                    u_addend    = t1_reg;
                end
            end
            S_D5: begin
                u_ctl.start = 1'b1;
                u_addend    = num_reg;
                u_bits      = t0_reg;
            end
            S_D6, S_A2: begin
                u_ctl.start = 1'b1;
                u_addend    = u_acc;
                u_bits      = u_acc;
            end
            S_D8, S_A4: begin
                u_ctl.start = 1'b1;
                u_addend    = kk_reg;
                u_bits      = sub_m(rx_reg, tmp_reg, m_reg);
            end
            S_A1: begin
                u_ctl.start = 1'b1;
                u_addend    = sub_m(gy_reg, ry_reg, m_reg);
                u_bits      = t0_reg;
            end
            default: begin
            end
        endcase
    end

    ecpsm_unit #(
        .WIDTH (FIELD_BITS)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (u_ctl),
        .bits    (u_bits),
        .addend  (u_addend),
        .divisor (u_div),
        .modulus (m_reg),
        .sts     (u_sts),
        .res_acc (u_acc),
        .res_rem (u_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            inv_ret_reg   <= S_IDLE;
            prime_reg     <= PRIME_RESET[FIELD_BITS-1:0];
            curve_a_reg   <= '0;
            m_reg         <= PRIME_RESET[FIELD_BITS-1:0];
            second_reg    <= 1'b0;
            fault_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_inf_reg   <= 1'b0;
            out_fault_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FIELD_PRIME: prime_reg   <= cfg_wr_data;
                    REG_CURVE_A:     curve_a_reg <= cfg_wr_data;
                endcase
            end

            if (fin_fire) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        k_reg  <= s_scalar;
                        gx_reg <= s_base_x;
                        gy_reg <= s_base_y;
                        m_reg  <= prime_reg;
                        if (prime_small) begin
                            fault_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end else begin
                            fault_reg <= 1'b0;
                            ret_reg   <= S_RA;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (u_sts.done) state_reg <= ret_reg;
                end
                S_RA: begin
                    a_reg     <= u_acc;
                    ret_reg   <= S_RX;
                    state_reg <= S_WAIT;
                end
                S_RX: begin
                    gx_reg    <= u_acc;
                    ret_reg   <= S_RY;
                    state_reg <= S_WAIT;
                end
                S_RY: begin
                    gy_reg     <= u_acc;
                    rx_reg     <= '0;
                    ry_reg     <= '0;
                    idx_reg    <= IDX_W'(SCALAR_BITS - 1);
                    second_reg <= 1'b0;
                    state_reg  <= S_DBL;
                end
                S_DBL: begin
                    if (r_inf) begin
                        state_reg <= second_reg ? S_STEP : S_POST;
                    end else if (ry_reg == '0) begin
                        fault_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        ret_reg   <= S_D1;
                        state_reg <= S_WAIT;
                    end
                end
                S_D1: begin
                    tmp_reg   <= add_m(u_acc, u_acc, m_reg);
                    state_reg <= S_D2;
                end
                S_D2: begin
                    tmp_reg   <= add_m(tmp_reg, u_acc, m_reg);
                    state_reg <= S_D3;
                end
                S_D3: begin
                    num_reg     <= add_m(tmp_reg, a_reg, m_reg);
                    r0_reg      <= m_reg;
                    r1_reg      <= add_m(ry_reg, ry_reg, m_reg);
                    t0_reg      <= '0;
                    t1_reg      <= FIELD_BITS'(1);
                    inv_ret_reg <= S_D5;
                    state_reg   <= S_INV_LOOP;
                end
                S_INV_LOOP: begin
                    if (r1_reg == '0) begin
                        if (r0_reg == FIELD_BITS'(1)) begin
                            state_reg <= inv_ret_reg;
                        end else begin
                            fault_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                    end else begin
                        ret_reg   <= S_INV_UPD;
                        state_reg <= S_WAIT;
                    end
                end
                S_INV_UPD: begin
                    r0_reg    <= r1_reg;
                    r1_reg    <= u_rem;
                    t0_reg    <= t1_reg;
                    t1_reg    <= sub_m(t0_reg, u_acc, m_reg);
                    state_reg <= S_INV_LOOP;
                end
                S_D5: begin
                    ret_reg   <= S_D6;
                    state_reg <= S_WAIT;
                end
                S_D6: begin
                    kk_reg    <= u_acc;
                    ret_reg   <= S_D7;
                    state_reg <= S_WAIT;
                end
                S_D7: begin
                    tmp_reg   <= sub_m(u_acc, add_m(rx_reg, rx_reg, m_reg), m_reg);
                    state_reg <= S_D8;
                end
                S_D8: begin
                    ret_reg   <= S_D9;
                    state_reg <= S_WAIT;
                end
                S_D9: begin
                    rx_reg    <= tmp_reg;
                    ry_reg    <= sub_m(u_acc, ry_reg, m_reg);
                    state_reg <= second_reg ? S_STEP : S_POST;
                end
                S_POST: begin
                    if (k_reg[idx_reg]) begin
                        second_reg <= 1'b1;
                        // adding the base to itself: double instead
                        if (rx_reg == gx_reg && ry_reg == gy_reg) state_reg <= S_DBL;
                        else state_reg <= S_ADD;
                    end else begin
                        state_reg <= S_STEP;
                    end
                end
                S_ADD: begin
                    if (r_inf) begin
                        rx_reg    <= gx_reg;
                        ry_reg    <= gy_reg;
                        state_reg <= S_STEP;
                    end else if (g_inf) begin
                        state_reg <= S_STEP;
                    end else if (rx_reg == gx_reg) begin
                        fault_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        r0_reg      <= m_reg;
                        r1_reg      <= sub_m(gx_reg, rx_reg, m_reg);
                        t0_reg      <= '0;
                        t1_reg      <= FIELD_BITS'(1);
                        inv_ret_reg <= S_A1;
                        state_reg   <= S_INV_LOOP;
                    end
                end
                S_A1: begin
                    ret_reg   <= S_A2;
                    state_reg <= S_WAIT;
                end
                S_A2: begin
                    kk_reg    <= u_acc;
                    ret_reg   <= S_A3;
                    state_reg <= S_WAIT;
                end
                S_A3: begin
                    tmp_reg   <= sub_m(sub_m(u_acc, rx_reg, m_reg), gx_reg, m_reg);
                    state_reg <= S_A4;
                end
                S_A4: begin
                    ret_reg   <= S_A5;
                    state_reg <= S_WAIT;
                end
                S_A5: begin
                    rx_reg    <= tmp_reg;
                    ry_reg    <= sub_m(u_acc, ry_reg, m_reg);
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    second_reg <= 1'b0;
                    if (idx_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        idx_reg   <= idx_reg - IDX_W'(1);
                        state_reg <= S_DBL;
                    end
                end
                S_FIN: begin
                    // hold until the previous result beat has gone
                    if (fin_fire) begin
                        out_fault_reg <= fault_reg;
                        out_x_reg     <= fault_reg ? '0 : rx_reg;
                        out_y_reg     <= fault_reg ? '0 : ry_reg;
                        out_inf_reg   <= !fault_reg && r_inf;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_x    = out_x_reg;
    assign m_result_y    = out_y_reg;
    assign m_at_infinity = out_inf_reg;
    assign m_fault       = out_fault_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(u_ctl.start && u_sts.busy))
        else $error("unit started while busy");

    a_wait_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT) |-> (u_sts.busy || u_sts.done))
        else $error("waiting on an idle unit");

    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault) |-> (!m_at_infinity && m_result_x == '0 && m_result_y == '0))
        else $error("fault beat carries coordinates");

    a_fin_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_valid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("result not presented on finish");

endmodule

`default_nettype wire

[rtl/core/ecpsm_unit.sv]
// Bit-serial modular multiply and combined divide/multiply step.
// One bit per cycle. Depends on ecpsm_pkg.
`default_nettype none

module ecpsm_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ecpsm_pkg::unit_ctl_t   ctl,
    input  wire logic [WIDTH-1:0]       bits,
    input  wire logic [WIDTH-1:0]       addend,
    input  wire logic [WIDTH-1:0]       divisor,
    input  wire logic [WIDTH-1:0]       modulus,
    output ecpsm_pkg::unit_sts_t        sts,
    output logic [WIDTH-1:0]            res_acc,
    output logic [WIDTH-1:0]            res_rem
);
    import ecpsm_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    function automatic logic [WIDTH-1:0] add_m(input logic [WIDTH-1:0] u,
                                               input logic [WIDTH-1:0] v,
                                               input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[WIDTH-1:0];
    endfunction

    unit_op_t         op_reg;
    logic [WIDTH-1:0] sh_reg;
    logic [WIDTH-1:0] addend_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   rem_sh;
    logic             qbit;
    logic [WIDTH:0]   rem_diff;
    logic [WIDTH-1:0] rem_next;
    logic             step_bit;
    logic [WIDTH-1:0] acc_dbl;
    logic [WIDTH-1:0] acc_next;

    // Restoring division and MSB-first modular accumulate share one step
    always_comb begin
        rem_sh   = {rem_reg, sh_reg[WIDTH-1]};
        qbit     = (rem_sh >= {1'b0, div_reg});
        rem_diff = rem_sh - {1'b0, div_reg};
        rem_next = qbit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        step_bit = (op_reg == UOP_MUL) ? sh_reg[WIDTH-1] : qbit;
        acc_dbl  = add_m(acc_reg, acc_reg, modulus);
        acc_next = step_bit ? add_m(acc_dbl, addend_reg, modulus) : acc_dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !ctl.start && busy_reg && (cnt_reg == '0);
            if (ctl.start) begin
                op_reg     <= ctl.op;
                sh_reg     <= bits;
                addend_reg <= addend;
                div_reg    <= divisor;
                acc_reg    <= '0;
                rem_reg    <= '0;
                cnt_reg    <= CNT_W'(WIDTH - 1);
                busy_reg   <= 1'b1;
            end else if (busy_reg) begin
                sh_reg  <= {sh_reg[WIDTH-2:0], 1'b0};
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res_acc  = acc_reg;
    assign res_rem  = rem_reg;

endmodule

`default_nettype wire
